// ----- rtl/core/tom_pkg.sv -----
// Shared types and constants of the token overlap marker.
`timescale 1ns / 1ps

package tom_pkg;

  localparam int TOKEN_BITS    = 16;
  localparam int SCORE_BITS    = 6;
  localparam int KIND_BITS     = 2;
  localparam int IN_TDATA_BITS = 16;
  localparam int OUT_TDATA_BITS = 24;

  localparam logic [KIND_BITS-1:0] KIND_TOKEN = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_OPEN  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLOSE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 start;
    logic                 fetch;
    logic                 advance;
    logic                 runend;
    logic                 emit_init;
    logic                 emit_rd;
    logic                 push;
    logic [KIND_BITS-1:0] push_kind;
    logic                 push_fin;
    logic                 set_inside;
    logic                 clr_inside;
    logic                 next_i;
    logic                 finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic m_zero;
    logic fetch_ok;
    logic match;
    logic scan_done;
    logic out_free;
    logic mark;
    logic in_mark;
    logic last_i;
  } sts_t;

endpackage

// ----- rtl/core/tom_ctrl.sv -----
// Sequencer for loading, run scanning and marked emission.
`timescale 1ns / 1ps

module tom_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tuser,
  input  logic          s_tlast,
  output logic          s_tready,
  input  tom_pkg::sts_t sts,
  output tom_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_START   = 4'd1;
  localparam logic [3:0] ST_FETCH   = 4'd2;
  localparam logic [3:0] ST_CMP     = 4'd3;
  localparam logic [3:0] ST_RUNEND  = 4'd4;
  localparam logic [3:0] ST_E_READ  = 4'd5;
  localparam logic [3:0] ST_E_A     = 4'd6;
  localparam logic [3:0] ST_E_B     = 4'd7;
  localparam logic [3:0] ST_E_CLOSE = 4'd8;
  localparam logic [3:0] ST_E_END   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid && s_tuser && s_tlast) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        if (sts.m_zero) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_E_READ;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = sts.fetch_ok ? ST_CMP : ST_RUNEND;
      end
      ST_CMP: begin
        if (sts.match) begin
          cmd.advance = 1'b1;
          state_next  = ST_FETCH;
        end else begin
          state_next = ST_RUNEND;
        end
      end
      ST_RUNEND: begin
        cmd.runend = 1'b1;
        if (sts.scan_done) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_E_READ;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_E_READ: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_E_A;
      end
      ST_E_A: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.in_mark) begin
            cmd.push_kind = tom_pkg::KIND_TOKEN;
            if (sts.mark) begin
              cmd.next_i = 1'b1;
              state_next = sts.last_i ? ST_E_END : ST_E_READ;
            end else begin
              state_next = ST_E_CLOSE;
            end
          end else if (sts.mark) begin
            cmd.push_kind  = tom_pkg::KIND_OPEN;
            cmd.set_inside = 1'b1;
            state_next     = ST_E_B;
          end else begin
            cmd.push_kind = tom_pkg::KIND_TOKEN;
            cmd.push_fin  = sts.last_i;
            cmd.next_i    = 1'b1;
            cmd.finish    = sts.last_i;
            state_next    = sts.last_i ? ST_IDLE : ST_E_READ;
          end
        end
      end
      ST_E_B: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = tom_pkg::KIND_TOKEN;
          cmd.next_i    = 1'b1;
          state_next    = sts.last_i ? ST_E_END : ST_E_READ;
        end
      end
      ST_E_CLOSE: begin
        if (sts.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_kind  = tom_pkg::KIND_CLOSE;
          cmd.push_fin   = sts.last_i;
          cmd.clr_inside = 1'b1;
          cmd.next_i     = 1'b1;
          cmd.finish     = sts.last_i;
          state_next     = sts.last_i ? ST_IDLE : ST_E_READ;
        end
      end
      ST_E_END: begin
        if (sts.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_kind  = tom_pkg::KIND_CLOSE;
          cmd.push_fin   = 1'b1;
          cmd.clr_inside = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/tom_datapath.sv -----
// Token stores, run scan registers, overlap marks and output register.
`timescale 1ns / 1ps

module tom_datapath #(
  parameter int SOURCE_LEN   = 32,
  parameter int DATABASE_LEN = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_action,
  input  logic [tom_pkg::TOKEN_BITS-1:0]         in_token,
  input  tom_pkg::cmd_t                          cmd,
  output tom_pkg::sts_t                          sts,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [tom_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
  output logic [tom_pkg::KIND_BITS-1:0]          m_tuser,
  output logic                                   m_tlast
);

  localparam int SIW = $clog2(SOURCE_LEN);
  localparam int SCW = $clog2(SOURCE_LEN + 1);
  localparam int DIW = $clog2(DATABASE_LEN);
  localparam int DCW = $clog2(DATABASE_LEN + 1);
  localparam int PADW = tom_pkg::OUT_TDATA_BITS - tom_pkg::TOKEN_BITS - tom_pkg::SCORE_BITS;

  logic [tom_pkg::TOKEN_BITS-1:0] src_mem [SOURCE_LEN];
  logic [tom_pkg::TOKEN_BITS-1:0] db_mem  [DATABASE_LEN];
  logic [tom_pkg::TOKEN_BITS-1:0] rd_src;
  logic [tom_pkg::TOKEN_BITS-1:0] rd_db;

  logic [SCW-1:0] n;
  logic [DCW-1:0] m;
  logic [SCW-1:0] si;
  logic [SCW-1:0] st;
  logic [DCW-1:0] di;
  logic [DCW-1:0] dt;
  logic [SCW-1:0] idx;
  logic [SOURCE_LEN-1:0] marks;
  logic [tom_pkg::SCORE_BITS-1:0] score;
  logic in_mark;

  logic [SCW-1:0] run;
  logic [SCW-1:0] st_inc;
  logic [DCW-1:0] di_inc;
  logic [SCW-1:0] idx_inc;
  logic           wr_src;
  logic           wr_db;
  logic [SIW-1:0] src_raddr;

  assign run     = st - si;
  assign st_inc  = st + SCW'(1);
  assign di_inc  = di + DCW'(1);
  assign idx_inc = idx + SCW'(1);
  assign wr_src  = cmd.load && in_action && (n < SCW'(SOURCE_LEN));
  assign wr_db   = cmd.load && !in_action && (m < DCW'(DATABASE_LEN));
  assign src_raddr = cmd.emit_rd ? idx[SIW-1:0] : st[SIW-1:0];

  // source store: one write port for loading, one read port shared by scan and emission
  always_ff @(posedge clk) begin
    if (wr_src) begin
      src_mem[n[SIW-1:0]] <= in_token;
    end
    if (cmd.fetch || cmd.emit_rd) begin
      rd_src <= src_mem[src_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_db) begin
      db_mem[m[DIW-1:0]] <= in_token;
    end
    if (cmd.fetch) begin
      rd_db <= db_mem[dt[DIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n       <= '0;
      m       <= '0;
      si      <= '0;
      st      <= '0;
      di      <= '0;
      dt      <= '0;
      idx     <= '0;
      marks   <= '0;
      score   <= '0;
      in_mark <= 1'b0;
    end else begin
      if (wr_src) begin
        n <= n + SCW'(1);
      end
      if (wr_db) begin
        m <= m + DCW'(1);
      end
      if (cmd.start) begin
        si    <= '0;
        st    <= '0;
        di    <= '0;
        dt    <= '0;
        marks <= '0;
        score <= '0;
      end
      if (cmd.advance) begin
        st <= st_inc;
        dt <= dt + DCW'(1);
      end
      if (cmd.runend) begin
        if (run > SCW'(1)) begin
          for (int k = 0; k < SOURCE_LEN; k++) begin
            if ((SCW'(k) >= si) && (SCW'(k) < st)) begin
              marks[k] <= 1'b1;
            end
          end
        end
        if (tom_pkg::SCORE_BITS'(run) > score) begin
          score <= tom_pkg::SCORE_BITS'(run);
        end
        // database scan wrapped: move the source position one past the last run's end and restart the database at zero
        if (di_inc >= m) begin
          si <= st_inc;
          st <= st_inc;
          di <= '0;
          dt <= '0;
        end else begin
          si <= st;
          di <= di_inc;
          dt <= di_inc;
        end
      end
      if (cmd.emit_init) begin
        idx     <= '0;
        in_mark <= 1'b0;
      end
      if (cmd.next_i) begin
        idx <= idx_inc;
      end
      if (cmd.set_inside) begin
        in_mark <= 1'b1;
      end else if (cmd.clr_inside) begin
        in_mark <= 1'b0;
      end
      if (cmd.finish) begin
        n <= '0;
        m <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= {{PADW{1'b0}}, score,
                  (cmd.push_kind == tom_pkg::KIND_TOKEN) ? rd_src
                                                         : {tom_pkg::TOKEN_BITS{1'b0}}};
      m_tuser <= cmd.push_kind;
      m_tlast <= cmd.push_fin;
    end
  end

  always_comb begin
    sts.m_zero    = (m == '0);
    sts.fetch_ok  = (st < n) && (dt < m);
    sts.match     = (rd_src == rd_db);
    sts.scan_done = (st >= n) || ((di_inc >= m) && (st_inc >= n));
    sts.out_free  = !m_tvalid || m_tready;
    sts.mark      = marks[idx[SIW-1:0]];
    sts.in_mark   = in_mark;
    sts.last_i    = (idx_inc == n);
  end

endmodule

// ----- rtl/core/token_overlap_marker_unit.sv -----
// Top level of the token overlap marker.
//
// Input stream s_*: one word per token. s_tuser = 0 loads a database token,
// 1 a source token; s_tdata is the token. A source word with s_tlast high
// ends the source sentence and starts a comparison. Tokens beyond the store
// depth are dropped. Loading takes one word per cycle.
// Output stream m_*: the source tokens in order with open and close marker
// words around overlapping regions; m_tuser gives the kind, m_tdata the token
// (zero on markers) and the score, m_tlast flags the final word.
// Sequence: a start step, then a fetch and a compare for each token pair
// compared and a run end for each database start position tried, paced by the
// single read port of each store; then a read and a push for each source token,
// an extra push per marker added, and a close for a region open at the end.
// s_tready is low from the closing source word until the final word is
// registered at the output. A stalled receiver holds the output register; the
// sequencer waits. Reset clears both counts, the marks and the output valid;
// stored tokens are left as they are and are overwritten by the next load.
`timescale 1ns / 1ps

module token_overlap_marker_unit #(
  parameter int SOURCE_LEN   = 32,
  parameter int DATABASE_LEN = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tom_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [15:0] token
  input  logic                                s_tuser,   // [0] action
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tom_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // [15:0] token_out, [21:16] score
  output logic [tom_pkg::KIND_BITS-1:0]       m_tuser,   // [1:0] kind
  output logic                                m_tlast
);

  tom_pkg::cmd_t cmd;
  tom_pkg::sts_t sts;

  tom_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tom_datapath #(
    .SOURCE_LEN   (SOURCE_LEN),
    .DATABASE_LEN (DATABASE_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_action (s_tuser),
    .in_token  (s_tdata[tom_pkg::TOKEN_BITS-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- rtl/core/tom_checker.sv -----
// Port checker for the token overlap marker, bound to the top level.
`timescale 1ns / 1ps

module tom_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [tom_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input logic [tom_pkg::KIND_BITS-1:0]      m_tuser,
  input logic                               m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tom_pkg::KIND_OPEN || m_tuser == tom_pkg::KIND_CLOSE)
      |-> (m_tdata[tom_pkg::TOKEN_BITS-1:0] == '0))
    else $error("marker word carries a token");

  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of an output frame");

endmodule

bind token_overlap_marker_unit tom_checker u_tom_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
